[rtl/core/ccs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the comment stripper
// Request payloads, scanner modes, end status codes and the character set
// that the scanner reacts to.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// Characters the scanner reacts to
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// End-of-text status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BLOCK  = 2'd1;
	localparam logic [1:0] ST_STRING = 2'd2;

	// Default depth of the result queue
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BLOCK  = 2'd1,
		MODE_LINE   = 2'd2,
		MODE_STRING = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       text_end;
		logic [1:0] status;
	} result_t;

	// Up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} qwrite_t;

endpackage

[rtl/core/ccs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front: byte scanner
// Classifies each accepted byte against the current mode, updates the
// scanner state and produces zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module ccs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  ccs_pkg::item_t  item,
	output ccs_pkg::qwrite_t wreq
);
	import ccs_pkg::*;

	mode_t      mode_q, mode_step;
	logic       slash_q, slash_step;
	logic       star_q, star_step;
	logic       bsl_q, bsl_step;
	logic [7:0] c;
	logic       is_last;
	logic       emit_slash, emit_c;
	logic [1:0] end_status;

	assign c       = item.in_byte;
	assign is_last = item.last;

	// Next state for one byte, before the end-of-text return to reset
	always_comb begin
		mode_step  = mode_q;
		slash_step = slash_q;
		star_step  = star_q;
		bsl_step   = bsl_q;
		case (mode_q)
			MODE_NORMAL: begin
				if (slash_q && c == CH_STAR) begin
					slash_step = 1'b0;
					mode_step  = MODE_BLOCK;
					star_step  = 1'b0;
				end else if (slash_q && c == CH_SLASH) begin
					slash_step = 1'b0;
					mode_step  = MODE_LINE;
				end else if (c == CH_SLASH && !is_last) begin
					slash_step = 1'b1;
				end else if (c == CH_QUOTE) begin
					slash_step = 1'b0;
					mode_step  = MODE_STRING;
					bsl_step   = 1'b0;
				end else begin
					slash_step = 1'b0;
				end
			end
			MODE_BLOCK: begin
				if (star_q && c == CH_SLASH) begin
					mode_step = MODE_NORMAL;
					star_step = 1'b0;
				end else begin
					star_step = (c == CH_STAR);
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) begin
					mode_step = MODE_NORMAL;
				end
			end
			MODE_STRING: begin
				if (c == CH_QUOTE && !bsl_q) begin
					mode_step = MODE_NORMAL;
					bsl_step  = 1'b0;
				end else begin
					bsl_step = (c == CH_BSLASH);
				end
			end
			default: begin
				mode_step = MODE_NORMAL;
			end
		endcase
	end

	// Decide which bytes go out for this input
	always_comb begin
		emit_slash = 1'b0;
		emit_c     = 1'b0;
		case (mode_q)
			MODE_NORMAL: begin
				if (slash_q) begin
					emit_slash = (c != CH_STAR) && (c != CH_SLASH);
					emit_c     = emit_slash;
				end else begin
					emit_c = !(c == CH_SLASH && !is_last);
				end
			end
			MODE_LINE:   emit_c = (c == CH_NL);
			MODE_STRING: emit_c = 1'b1;
			MODE_BLOCK:  emit_c = 1'b0;
			default:     emit_c = 1'b0;
		endcase
	end

	// Status of the text as it stands after this byte
	always_comb begin
		case (mode_step)
			MODE_BLOCK:  end_status = ST_BLOCK;
			MODE_STRING: end_status = ST_STRING;
			default:     end_status = ST_OK;
		endcase
	end

	// Build the queue write request
	always_comb begin
		wreq = '0;
		if (emit_slash) begin
			wreq.r0.out_byte = CH_SLASH;
			wreq.r0.has_byte = 1'b1;
			wreq.r1.out_byte = c;
			wreq.r1.has_byte = 1'b1;
			wreq.cnt         = 2'd2;
		end else if (emit_c) begin
			wreq.r0.out_byte = c;
			wreq.r0.has_byte = 1'b1;
			wreq.cnt         = 2'd1;
		end
		// Tag the final result, or add a status-only one
		if (is_last) begin
			if (wreq.cnt == 2'd2) begin
				wreq.r1.text_end = 1'b1;
				wreq.r1.status   = end_status;
			end else begin
				wreq.cnt         = 2'd1;
				wreq.r0.text_end = 1'b1;
				wreq.r0.status   = end_status;
			end
		end
		if (!accept) begin
			wreq.cnt = 2'd0;
		end
	end

	// Advance scanner state; drop back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			bsl_q   <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				mode_q  <= MODE_NORMAL;
				slash_q <= 1'b0;
				star_q  <= 1'b0;
				bsl_q   <= 1'b0;
			end else begin
				mode_q  <= mode_step;
				slash_q <= slash_step;
				star_q  <= star_step;
				bsl_q   <= bsl_step;
			end
		end
	end

endmodule

[rtl/core/ccs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_queue: result queue
// Register queue that takes up to two results per cycle from the scanner
// and hands out one result per cycle at the output side while pop is high.
// ----------------------------------------------------------------------------
module ccs_queue #(
	parameter int DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ccs_pkg::qwrite_t wreq,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output ccs_pkg::result_t result
);
	import ccs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH - 1);

	result_t          mem [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q, wptr_p1, wptr_p2;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	assign wptr_p1 = ptr_inc(wptr_q);
	assign wptr_p2 = ptr_inc(wptr_p1);
	assign do_pop  = pop && !empty;
	assign empty   = (count_q == '0);
	// Hold off requests unless two slots are free
	assign full    = (count_q >= CNT_FULL);
	assign result  = mem[rptr_q];

	// Store incoming results
	always_ff @(posedge clk) begin
		if (wreq.cnt != 2'd0) begin
			mem[wptr_q] <= wreq.r0;
		end
		if (wreq.cnt == 2'd2) begin
			mem[wptr_p1] <= wreq.r1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			case (wreq.cnt)
				2'd1:    wptr_q <= wptr_p1;
				2'd2:    wptr_q <= wptr_p2;
				default: wptr_q <= wptr_q;
			endcase
			if (do_pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			count_q <= count_q + CNT_W'(wreq.cnt) - CNT_W'(do_pop);
		end
	end

endmodule

[rtl/core/c_comment_stripper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper: C comment removal on a byte stream
// Drops line and block comments, passes strings and other text through.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while full is low and gives out at most
// one result per clock. The scanner decides each byte in the cycle it is
// accepted and writes up to two results at once into a small queue (QUEUE_DEPTH
// entries); full rises when fewer than two slots are free, so a held slash
// released together with the following byte never overflows it. At the
// default depth and with pop held high the block sustains one byte per cycle;
// input stalls only when the reader stalls. The final result of a text
// carries text_end and the end status.
module c_comment_stripper #(
	parameter int QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ccs_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output ccs_pkg::result_t result
);
	import ccs_pkg::*;

	qwrite_t wreq;
	logic    accept;

	assign accept = push && !full;

	// Scan and classify incoming bytes
	ccs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.wreq   (wreq)
	);

	// Buffer results toward the reader
	ccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wreq   (wreq),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.result (result)
	);

endmodule

[rtl/core/ccs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker: port-level checks of the comment stripper
// Watches the top-level ports and flags malformed or lost results.
// ----------------------------------------------------------------------------
module ccs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input ccs_pkg::item_t   item,
	input logic             empty,
	input logic             pop,
	input ccs_pkg::result_t result
);
	import ccs_pkg::*;

	// Hold a waiting result until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

	// Keep status clear on results that do not end a text
	a_status_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.text_end) |-> (result.status == ST_OK))
		else $error("status set on a mid-text result");

	// Allow a byte-less result only as the end of a text
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.has_byte) |-> (result.text_end && result.out_byte == 8'h00))
		else $error("malformed status-only result");

	// Never show an undefined status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == ST_OK || result.status == ST_BLOCK ||
			result.status == ST_STRING))
		else $error("undefined status code");

	// Always leave a result waiting after the last byte of a text is taken
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.last) |=> !empty)
		else $error("final request left no result");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
